>>> src/c3cm_pkg.sv
// Shared constants and types of the 3x3 color magnitude filter.
package c3cm_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int COEF_BITS = 5;
	localparam int NUM_TAPS = 9;
	localparam int KW_BITS = NUM_TAPS * COEF_BITS;
	localparam int ADDR_BITS = $clog2(MAX_WIDTH);
	localparam int COL_BITS = 11;
	localparam int ROW_BITS = 12;
	localparam int WCFG_BITS = 12;
	localparam int HCFG_BITS = 13;
	localparam int PIX_BITS = 24;
	localparam int SUM_BITS = 8 + COEF_BITS + 5;
	localparam int SQ_BITS = 2 * SUM_BITS + 2;

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_KERNEL = 2'd2;

	typedef logic [PIX_BITS-1:0] pixel_t;

	typedef struct packed {
		logic load;
		logic start;
		logic [1:0] sel;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic [3:0] need;
		logic done;
	} status_t;

endpackage

>>> src/c3cm_datapath.sv
// Datapath: line stores, window, convolution, square root and output register.
module c3cm_datapath (
	input logic clk,
	input logic arst_n,
	input c3cm_pkg::cmd_t cmd,
	output c3cm_pkg::status_t stat,
	input logic [23:0] in_pixel,
	input logic [c3cm_pkg::WCFG_BITS-1:0] cfg_w,
	input logic [c3cm_pkg::HCFG_BITS-1:0] cfg_h,
	input logic [c3cm_pkg::KW_BITS-1:0] cfg_k,
	output logic [7:0] mag,
	output logic [c3cm_pkg::COL_BITS-1:0] col,
	output logic [c3cm_pkg::ROW_BITS-1:0] row,
	output logic fdone
);
	localparam int AB = c3cm_pkg::ADDR_BITS;
	localparam int SB = c3cm_pkg::SUM_BITS;
	localparam int QB = c3cm_pkg::SQ_BITS;

	c3cm_pkg::pixel_t ram1 [c3cm_pkg::MAX_WIDTH];
	c3cm_pkg::pixel_t ram2 [c3cm_pkg::MAX_WIDTH];
	c3cm_pkg::pixel_t win_q [3][3];
	c3cm_pkg::pixel_t px_q;
	logic [c3cm_pkg::COL_BITS-1:0] x_q;
	logic [c3cm_pkg::ROW_BITS-1:0] y_q;
	logic [c3cm_pkg::COL_BITS-1:0] col_q;
	logic [c3cm_pkg::ROW_BITS-1:0] row_q;
	logic [AB-1:0] idx;
	logic [13:0] wl, hl;
	logic row_end, last_row;

	assign idx = (14'(x_q) < 14'(c3cm_pkg::MAX_WIDTH)) ? x_q[AB-1:0] : AB'(c3cm_pkg::MAX_WIDTH - 1);
	always_comb begin
		wl = (cfg_w == '0) ? 14'd1 : ((14'(cfg_w) > 14'(c3cm_pkg::MAX_WIDTH))
			? 14'(c3cm_pkg::MAX_WIDTH) : 14'(cfg_w));
		hl = (cfg_h == '0) ? 14'd1 : ((14'(cfg_h) > 14'(c3cm_pkg::MAX_HEIGHT))
			? 14'(c3cm_pkg::MAX_HEIGHT) : 14'(cfg_h));
	end
	assign row_end = 14'(x_q) >= wl - 14'd1;
	assign last_row = 14'(y_q) >= hl - 14'd1;

	// stage 0: latch pixel; stage 1: read stores (registered)
	c3cm_pkg::pixel_t a1_q, a2_q;
	always_ff @(posedge clk) begin
		if (cmd.load) px_q <= in_pixel;
		a1_q <= ram1[idx];
		a2_q <= ram2[idx];
	end

	logic [3:0] need_q;
	logic y1_q, x1_q, y0_q, x0_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++) win_q[r][c] <= '0;
		end else if (cmd.advance) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= a2_q;
			win_q[1][2] <= a1_q;
			win_q[2][2] <= px_q;
			if (row_end) begin
				x_q <= '0;
				y_q <= last_row ? '0 : y_q + 1'b1;
			end else x_q <= x_q + 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			ram2[idx] <= a1_q;
			ram1[idx] <= px_q;
			need_q <= {last_row & row_end, last_row & (x_q != 0),
				(y_q != 0) & row_end, (y_q != 0) & (x_q != 0)};
			y1_q <= (y_q == 1);
			x1_q <= (x_q == 1);
			y0_q <= (y_q == 0);
			x0_q <= (x_q == 0);
			col_q <= x_q;
			row_q <= y_q;
		end
	end
	assign stat.need = need_q;

	// compute: one tap per cycle over nine taps, then square root
	logic [3:0] tap_q;
	logic signed [SB-1:0] acc_q [3];
	logic [QB-1:0] sq_q;
	logic [3:0] bit_q;
	logic [7:0] r_q;
	logic busy_q, sqb_q, done_q;
	logic [1:0] sel_q;
	logic [1:0] rsel, csel;
	logic [1:0] ky, kx;
	c3cm_pkg::pixel_t p;
	logic signed [c3cm_pkg::COEF_BITS-1:0] k;

	always_comb begin
		ky = 2'd0;
		kx = 2'd0;
		case (tap_q)
			4'd0: begin ky = 0; kx = 0; end
			4'd1: begin ky = 0; kx = 1; end
			4'd2: begin ky = 0; kx = 2; end
			4'd3: begin ky = 1; kx = 0; end
			4'd4: begin ky = 1; kx = 1; end
			4'd5: begin ky = 1; kx = 2; end
			4'd6: begin ky = 2; kx = 0; end
			4'd7: begin ky = 2; kx = 1; end
			default: begin ky = 2; kx = 2; end
		endcase
		if (sel_q[1]) rsel = (ky == 0) ? (y0_q ? 2'd2 : 2'd1) : 2'd2;
		else rsel = (ky == 0) ? (y1_q ? 2'd1 : 2'd0) : ky;
		if (sel_q[0]) csel = (kx == 0) ? (x0_q ? 2'd2 : 2'd1) : 2'd2;
		else csel = (kx == 0) ? (x1_q ? 2'd1 : 2'd0) : kx;
		p = win_q[rsel][csel];
		k = cfg_k[tap_q*c3cm_pkg::COEF_BITS +: c3cm_pkg::COEF_BITS];
	end

	logic [7:0] tr;
	assign tr = r_q | (8'd1 << bit_q[2:0]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sqb_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				tap_q <= '0;
				sel_q <= cmd.sel;
				for (int c = 0; c < 3; c++) acc_q[c] <= '0;
			end else if (busy_q) begin
				for (int c = 0; c < 3; c++)
					acc_q[c] <= acc_q[c] + SB'(k * $signed({1'b0, p[8*c +: 8]}));
				if (tap_q == 4'd8) begin
					busy_q <= 1'b0;
					sqb_q <= 1'b1;
					bit_q <= 4'd8;
				end else tap_q <= tap_q + 1'b1;
			end else if (sqb_q && bit_q == 4'd8) begin
				sq_q <= QB'(acc_q[0]*acc_q[0]) + QB'(acc_q[1]*acc_q[1]) + QB'(acc_q[2]*acc_q[2]);
				r_q <= '0;
				bit_q <= 4'd7;
			end else if (sqb_q) begin
				if (QB'(tr) * QB'(tr) <= sq_q) r_q <= tr;
				if (bit_q == 4'd0) begin
					sqb_q <= 1'b0;
					done_q <= 1'b1;
				end else bit_q <= bit_q - 1'b1;
			end
		end
	end
	assign stat.done = done_q;

	always_comb begin
		mag = (sq_q >= QB'(65536)) ? 8'hFF : r_q;
		fdone = sel_q == 2'b11;
		col = sel_q[0] ? col_q : col_q - 1'b1;
		row = sel_q[1] ? row_q : row_q - 1'b1;
	end
endmodule

>>> src/c3cm_ctrl.sv
// Controller: sequences load, store access, window shift and result emission.
module c3cm_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	output logic in_ready,
	output c3cm_pkg::cmd_t cmd,
	input c3cm_pkg::status_t stat,
	output logic out_valid,
	input logic out_ready,
	output logic last
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001, S_READ = 6'b000010, S_ADV = 6'b000100,
		S_PICK = 6'b001000, S_CALC = 6'b010000, S_OUT = 6'b100000
	} state_t;
	state_t state_q;
	logic [3:0] left_q;
	logic [1:0] cur;

	always_comb begin
		cur = 2'd0;
		if (left_q[0]) cur = 2'd0;
		else if (left_q[1]) cur = 2'd1;
		else if (left_q[2]) cur = 2'd2;
		else cur = 2'd3;
	end

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		cmd.advance = state_q == S_ADV;
		cmd.start = (state_q == S_PICK) && (left_q != 0);
		cmd.sel = cur;
	end
	assign in_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign last = ((left_q >> cur) >> 1) == 4'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			left_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_READ;
				S_READ: state_q <= S_ADV;
				S_ADV: state_q <= S_PICK;
				S_PICK: begin
					if (left_q == 0 && stat.need == 0) state_q <= S_IDLE;
					else if (left_q == 0) left_q <= stat.need;
					else state_q <= S_CALC;
				end
				S_CALC: if (stat.done) state_q <= S_OUT;
				S_OUT: if (out_ready) begin
					left_q[cur] <= 1'b0;
					state_q <= last ? S_IDLE : S_PICK;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n) in_fire |-> !out_valid)
		else $error("input taken during output");
	assert property (@(posedge clk) disable iff (!arst_n) stat.done |-> state_q == S_CALC)
		else $error("stray done");
endmodule

>>> src/conv3x3_color_magnitude.sv
// Top level of the 3x3 RGB filter with color-vector magnitude output.
// Usage:
//  s_axis: one RGB pixel per transaction in raster order, tdata = red, green, blue.
//  m_axis: zero to four results per pixel; tdata = magnitude, out_column, out_row;
//  tuser = frame_done; tlast marks the last result caused by a pixel.
//  cfg: index 0 image_width, 1 image_height, 2 kernel_weights; write while idle.
//  Results lag the input by one row and one column; the last column and the
//  last row release the pending results.
//  Each result uses nine tap steps of the shared multiply-accumulate, one
//  square step and eight square-root steps; a new pixel is accepted only
//  after all results of the previous pixel have been emitted.
//  Reset clears counters and window; line stores are not cleared.
//  While m_axis_tready is low the result holds and no pixel is accepted.
module conv3x3_color_magnitude (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [23:0] s_axis_tdata, // red, green, blue
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // magnitude, out_column, out_row, zero fill
	output logic m_axis_tlast,
	output logic m_axis_tuser, // frame_done
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [63:0] cfg_data
);
	logic [c3cm_pkg::WCFG_BITS-1:0] w_q;
	logic [c3cm_pkg::HCFG_BITS-1:0] h_q;
	logic [c3cm_pkg::KW_BITS-1:0] k_q;
	c3cm_pkg::cmd_t cmd;
	c3cm_pkg::status_t stat;
	logic fire;
	logic [7:0] mag;
	logic [c3cm_pkg::COL_BITS-1:0] col;
	logic [c3cm_pkg::ROW_BITS-1:0] row;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= c3cm_pkg::WCFG_BITS'(2048);
			h_q <= c3cm_pkg::HCFG_BITS'(4096);
			k_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				c3cm_pkg::REG_WIDTH: w_q <= cfg_data[c3cm_pkg::WCFG_BITS-1:0];
				c3cm_pkg::REG_HEIGHT: h_q <= cfg_data[c3cm_pkg::HCFG_BITS-1:0];
				c3cm_pkg::REG_KERNEL: k_q <= cfg_data[c3cm_pkg::KW_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign fire = s_axis_tvalid & s_axis_tready;

	c3cm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(fire), .in_ready(s_axis_tready),
		.cmd(cmd), .stat(stat), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.last(m_axis_tlast)
	);

	c3cm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .in_pixel(s_axis_tdata),
		.cfg_w(w_q), .cfg_h(h_q), .cfg_k(k_q), .mag(mag), .col(col), .row(row),
		.fdone(m_axis_tuser)
	);

	assign m_axis_tdata = {1'b0, row, col, mag};
endmodule

>>> tb/c3cm_checker.sv
// Checker for the 3x3 color magnitude filter: predicts results from observed transactions.
module c3cm_checker
	import c3cm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic m_axis_tlast,
	input logic m_axis_tuser,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [63:0] cfg_data,
	output int errors,
	output int pending,
	output int checked
);

	typedef struct packed {
		logic [7:0] magnitude;
		logic [COL_BITS-1:0] column;
		logic [ROW_BITS-1:0] row;
		logic last_of_run;
		logic frame_done;
	} mag_result_t;

	mag_result_t mag_q[$];

	pixel_t line1 [MAX_WIDTH];
	pixel_t line2 [MAX_WIDTH];
	pixel_t win [3][3];
	int unsigned col_cnt, row_cnt;
	logic [WCFG_BITS-1:0] width_reg;
	logic [HCFG_BITS-1:0] height_reg;
	logic [KW_BITS-1:0] kernel_reg;

	function automatic logic [7:0] window_magnitude(int rs[3], int cs[3]);
		longint sum[3];
		longint sq;
		logic signed [COEF_BITS-1:0] c;
		pixel_t p;
		int unsigned root;
		sum = '{0, 0, 0};
		for (int ky = 0; ky < 3; ky++)
			for (int kx = 0; kx < 3; kx++) begin
				p = win[rs[ky]][cs[kx]];
				c = kernel_reg[(ky * 3 + kx) * COEF_BITS +: COEF_BITS];
				for (int ch = 0; ch < 3; ch++)
					sum[ch] += longint'(c) * longint'(p[8 * ch +: 8]);
			end
		sq = sum[0] * sum[0] + sum[1] * sum[1] + sum[2] * sum[2];
		if (sq >= 65536)
			return 8'hFF;
		root = 0;
		for (int b = 7; b >= 0; b--)
			if ((root | (1 << b)) * (root | (1 << b)) <= sq)
				root = root | (1 << b);
		return root[7:0];
	endfunction

	task automatic predict_pixel(pixel_t px);
		int unsigned w, h, x, y, idx;
		pixel_t a1, a2;
		logic row_end, last_row;
		int n;
		int rs_norm[3], rs_last[3], cs_prev[3], cs_cur[3];
		mag_result_t r;
		w = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
		h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
		x = col_cnt;
		y = row_cnt;
		idx = (x < MAX_WIDTH) ? x : MAX_WIDTH - 1;
		a1 = line1[idx];
		a2 = line2[idx];
		row_end = (x >= w - 1);
		last_row = (y >= h - 1);
		n = 0;
		line2[idx] = a1;
		line1[idx] = px;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = a2;
		win[1][2] = a1;
		win[2][2] = px;
		rs_norm = '{(y == 1) ? 1 : 0, 1, 2};
		rs_last = '{(y == 0) ? 2 : 1, 2, 2};
		cs_prev = '{(x == 1) ? 1 : 0, 1, 2};
		cs_cur = '{(x == 0) ? 2 : 1, 2, 2};
		if (y >= 1) begin
			if (x >= 1) begin
				r = '{window_magnitude(rs_norm, cs_prev), COL_BITS'(x - 1), ROW_BITS'(y - 1),
					1'b0, 1'b0};
				mag_q.push_back(r);
				n++;
			end
			if (row_end) begin
				r = '{window_magnitude(rs_norm, cs_cur), COL_BITS'(x), ROW_BITS'(y - 1),
					1'b0, 1'b0};
				mag_q.push_back(r);
				n++;
			end
		end
		if (last_row) begin
			if (x >= 1) begin
				r = '{window_magnitude(rs_last, cs_prev), COL_BITS'(x - 1), ROW_BITS'(y),
					1'b0, 1'b0};
				mag_q.push_back(r);
				n++;
			end
			if (row_end) begin
				r = '{window_magnitude(rs_last, cs_cur), COL_BITS'(x), ROW_BITS'(y),
					1'b0, 1'b1};
				mag_q.push_back(r);
				n++;
			end
		end
		if (n > 0)
			mag_q[mag_q.size() - 1].last_of_run = 1'b1;
		if (row_end) begin
			col_cnt = 0;
			row_cnt = last_row ? 0 : y + 1;
		end else begin
			col_cnt = x + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mag_result_t e;
		mag_result_t a;
		if (!arst_n) begin
			mag_q.delete();
			for (int i = 0; i < MAX_WIDTH; i++) begin
				line1[i] = '0;
				line2[i] = '0;
			end
			win = '{default: '0};
			col_cnt = 0;
			row_cnt = 0;
			width_reg = 12'd2048;
			height_reg = 13'd4096;
			kernel_reg = '0;
			errors <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH: width_reg = cfg_data[WCFG_BITS-1:0];
					REG_HEIGHT: height_reg = cfg_data[HCFG_BITS-1:0];
					REG_KERNEL: kernel_reg = cfg_data[KW_BITS-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				a = '{m_axis_tdata[7:0], m_axis_tdata[18:8], m_axis_tdata[30:19],
					m_axis_tlast, m_axis_tuser};
				if (mag_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result: mag %0d col %0d row %0d last %0b done %0b",
							a.magnitude, a.column, a.row, a.last_of_run, a.frame_done);
					errors <= errors + 1;
				end else begin
					e = mag_q.pop_front();
					if (a !== e) begin
						if (errors < 10)
							$display("mismatch: exp mag %0d col %0d row %0d last %0b done %0b, got mag %0d col %0d row %0d last %0b done %0b",
								e.magnitude, e.column, e.row, e.last_of_run, e.frame_done,
								a.magnitude, a.column, a.row, a.last_of_run, a.frame_done);
						errors <= errors + 1;
					end
					checked <= checked + 1;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_pixel(s_axis_tdata);
			pending <= mag_q.size();
		end
	end

endmodule

>>> tb/tb_conv3x3_color_magnitude.sv
// Testbench top for the 3x3 color magnitude filter: stimulus, handshakes and verdict.
module tb_conv3x3_color_magnitude;
	import c3cm_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	int errors, pending, checked;
	int gap_pct = 0;
	int stall_pct = 0;
	int cycles = 0;
	int pixels_sent = 0;
	int frames_run = 0;

	always #2 clk = ~clk;

	conv3x3_color_magnitude dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	c3cm_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .checked(checked)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	task automatic write_reg(logic [1:0] idx, logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= {$urandom, $urandom} & ~((64'd1 << KW_BITS) - 1) | value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic send_pixel(logic [23:0] px);
		if ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
		pixels_sent++;
	endtask

	function automatic logic [23:0] make_pixel(int mode);
		logic [23:0] px;
		case (mode)
			0: px = 24'($urandom);
			1: px = {{8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
				{8{1'($urandom_range(1))}}};
			default: px = {4'h0, 4'($urandom), 4'h0, 4'($urandom), 4'h0, 4'($urandom)};
		endcase
		return px;
	endfunction

	task automatic run_frame(logic [11:0] w, logic [12:0] h, logic [44:0] kw, int count,
		int mode);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_KERNEL, kw);
		for (int i = 0; i < count; i++)
			send_pixel(make_pixel(mode));
		s_axis_tvalid <= 1'b0;
		frames_run++;
		drain();
	endtask

	initial begin
		int w, h;
		int budget;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		run_frame(12'd3, 13'd3, 45'd1 << (4 * COEF_BITS), 9, 1);
		run_frame(12'd1, 13'd1, {9{5'b10000}}, 1, 1);
		run_frame(12'd0, 13'd0, {9{5'b01111}}, 1, 0);
		run_frame(12'd2, 13'd2, {9{5'b10000}}, 4, 1);
		write_reg(2'd3, 64'h5A5A);

		// oversized width, row closed by a reduced width
		run_frame(12'd4095, 13'd1, 45'({$urandom, $urandom}), 20, 0);
		write_reg(REG_WIDTH, 12'd21);
		send_pixel(make_pixel(0));
		s_axis_tvalid <= 1'b0;
		drain();

		// row count beyond a reduced height ends the frame
		run_frame(12'd2, 13'd8191, 45'({$urandom, $urandom}), 10, 0);
		write_reg(REG_HEIGHT, 13'd3);
		send_pixel(make_pixel(0));
		send_pixel(make_pixel(0));
		s_axis_tvalid <= 1'b0;
		drain();

		// column count beyond a reduced width ends the row
		run_frame(12'd8, 13'd1, 45'({$urandom, $urandom}), 5, 0);
		write_reg(REG_WIDTH, 12'd3);
		send_pixel(make_pixel(1));
		s_axis_tvalid <= 1'b0;
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 55; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 55; end
				default: begin gap_pct = 26; stall_pct = 26; end
			endcase
			budget = 0;
			while (budget < 25) begin
				w = $urandom_range(1, 6);
				h = $urandom_range(1, 5);
				run_frame(12'(w), 13'(h), 45'({$urandom, $urandom}), w * h,
					$urandom_range(2));
				budget += w * h;
			end
		end

		gap_pct = 0;
		stall_pct = 0;
		drain();
		$display("covered %0d frames, %0d pixels, %0d results checked", frames_run,
			pixels_sent, checked);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
src/c3cm_pkg.sv
src/c3cm_datapath.sv
src/c3cm_ctrl.sv
src/conv3x3_color_magnitude.sv
tb/c3cm_checker.sv
tb/tb_conv3x3_color_magnitude.sv
